FILE: rtl/core/pbs_pkg.sv
// ============================================================================
// pbs_pkg
// Types, constants and phase timing tables for the beep pattern sequencer.
// ============================================================================
package pbs_pkg;

    // Pattern rank; a higher rank preempts a lower one.
    typedef enum logic [1:0] {
        RANK_NONE   = 2'd0,
        RANK_KEY    = 2'd1,
        RANK_FINISH = 2'd2,
        RANK_ERROR  = 2'd3
    } t_rank;

    // Operation codes of an input word.
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Widths of the sequencer state.
    localparam int PHASE_W = 3;
    localparam int TIME_W  = 9;
    localparam int MS_W    = 16;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [MS_W-1:0]    t_ms;

    // Phase counts of each pattern.
    localparam t_phase KEY_LEN    = 3'd1;
    localparam t_phase FINISH_LEN = 3'd5;
    localparam t_phase ERROR_LEN  = 3'd7;

    localparam t_time KEY_MS = 9'd300;
    localparam t_time FINISH_MS [5] = '{9'd200, 9'd120, 9'd200, 9'd120, 9'd300};
    localparam t_time ERROR_MS  [7] = '{9'd100, 9'd100, 9'd100, 9'd100, 9'd100,
                                        9'd100, 9'd500};

    // Number of phases in a pattern; zero when no pattern runs.
    function automatic t_phase phases_of(input t_rank rank);
        t_phase n;
        case (rank)
            RANK_KEY:    n = KEY_LEN;
            RANK_FINISH: n = FINISH_LEN;
            RANK_ERROR:  n = ERROR_LEN;
            default:     n = '0;
        endcase
        return n;
    endfunction

    // Duration of one phase in milliseconds; zero when no pattern runs or past the last finish or error phase.
    function automatic t_time length_of(input t_rank rank, input t_phase ph);
        t_time t;
        t = '0;
        case (rank)
            RANK_KEY: begin
                t = KEY_MS;
            end
            RANK_FINISH: begin
                if (ph < FINISH_LEN) t = FINISH_MS[ph];
            end
            RANK_ERROR: begin
                if (ph < ERROR_LEN) t = ERROR_MS[ph];
            end
            default: begin
                t = '0;
            end
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/core/pbs_if.sv
// ============================================================================
// pbs_if
// Valid/ready channels that carry input and result words of the sequencer.
// ============================================================================

// Input channel: one command or time update word.
interface pbs_in_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [1:0]           requested_pattern;
    logic [15:0]          delta_ms;

    modport source (output valid, output opcode, output requested_pattern,
                    output delta_ms, input ready);
    modport sink   (input valid, input opcode, input requested_pattern,
                    input delta_ms, output ready);
endinterface

// Result channel: buzzer level and busy flag.
interface pbs_out_if;
    logic valid;
    logic ready;
    logic buzz;
    logic busy_res;

    modport source (output valid, output buzz, output busy_res, input ready);
    modport sink   (input valid, input buzz, input busy_res, output ready);
endinterface

FILE: rtl/core/priority_beep_pattern_sequencer.sv
// A pattern request passes through S_STEP and then S_DONE before its result word;
// a time update stays in S_STEP for each of the n (0 to 7) phases the elapsed time
// passes, then moves to S_DONE. One shared subtractor takes one phase a cycle.
// The next word is accepted the cycle after the result is registered.
// Reset (synchronous, active low) stops any pattern and empties the result register.
// ============================================================================
// priority_beep_pattern_sequencer
// Runs the key point, finish and error buzzer patterns with rank priority and
// steps phase timing through a shared compare and subtract unit.
// ============================================================================
module priority_beep_pattern_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbs_in_if.sink    i_in,
    pbs_out_if.source o_out
);
    import pbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_rank  r_active, n_active;
    t_phase r_phase, n_phase;
    t_time  r_tl, n_tl;
    t_ms    r_left, n_left;
    logic   r_op, n_op;
    t_rank  r_req, n_req;
    logic [3:0] r_guard, n_guard;
    logic   r_out_valid, n_out_valid;
    logic   r_buzzer, n_buzzer;
    logic   r_busy, n_busy;

    logic [MS_W:0] diff;
    logic [MS_W:0] neg_diff;
    logic          borrow;
    t_phase        phase_inc;
    logic          in_hs;

    // Shared unit: remaining time minus the current phase length.
    assign diff      = {1'b0, r_left} - {{(MS_W+1-TIME_W){1'b0}}, r_tl};
    assign neg_diff  = '0 - diff;
    assign borrow    = diff[MS_W];
    assign phase_inc = r_phase + 3'd1;
    assign in_hs     = i_in.valid && i_in.ready;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.buzz      = r_buzzer;
    assign o_out.busy_res  = r_busy;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_phase     = r_phase;
        n_tl        = r_tl;
        n_left      = r_left;
        n_op        = r_op;
        n_req       = r_req;
        n_guard     = r_guard;
        n_out_valid = r_out_valid;
        n_buzzer    = r_buzzer;
        n_busy      = r_busy;

        // The result word leaves when the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_hs) begin
                    n_op    = i_in.opcode;
                    n_req   = t_rank'(i_in.requested_pattern);
                    n_left  = i_in.delta_ms;
                    n_guard = '0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_op == OP_REQUEST) begin
                    // A nonzero request starts or restarts unless it ranks lower.
                    if (r_req != RANK_NONE && r_req >= r_active) begin
                        n_active = r_req;
                        n_phase  = '0;
                        n_tl     = length_of(r_req, '0);
                    end
                    n_state = S_DONE;
                end else if (r_active == RANK_NONE || borrow || r_guard == 4'd8) begin
                    // No pattern runs, the guard limit is reached, or time left falls within the current phase.
                    if (r_active != RANK_NONE) begin
                        n_tl = borrow ? neg_diff[TIME_W-1:0] : '0;
                    end
                    n_state = S_DONE;
                end else begin
                    // The elapsed time covers the whole phase: move to the next.
                    n_left  = diff[MS_W-1:0];
                    n_phase = phase_inc;
                    n_guard = r_guard + 4'd1;
                    if (phase_inc >= phases_of(r_active)) begin
                        n_active = RANK_NONE;
                        n_tl     = '0;
                    end else begin
                        n_tl = length_of(r_active, phase_inc);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_busy      = (r_active != RANK_NONE);
                    n_buzzer    = (r_active != RANK_NONE) && !r_phase[0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= RANK_NONE;
            r_phase     <= '0;
            r_tl        <= '0;
            r_guard     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_tl        <= n_tl;
            r_guard     <= n_guard;
            r_out_valid <= n_out_valid;
        end
        r_left   <= n_left;
        r_op     <= n_op;
        r_req    <= n_req;
        r_buzzer <= n_buzzer;
        r_busy   <= n_busy;
    end

    // A running pattern always has time left between words.
    a_time_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_active != RANK_NONE) |-> (r_tl != '0))
        else $error("active pattern with no time left");

    // The buzzer never sounds in a result that reports idle.
    a_buzz_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_buzzer) |-> r_busy)
        else $error("buzzer on while not busy");

    // An accepted word blocks new input until its result is registered.
    a_hold_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_hs |=> !i_in.ready)
        else $error("input accepted while a word is in work");

    // The phase walk never runs past the guard limit.
    a_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= 4'd8)
        else $error("phase walk exceeded its limit");

endmodule

FILE: dv/pbs_beep_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pbs_beep_checker
// Watches both channels of the beep pattern sequencer. Each accepted input
// word runs through a cycle-free model of the pattern timer. The model's
// buzzer and busy levels are queued and compared with each accepted result
// word in order.
// ============================================================================
module pbs_beep_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pbs_in_if    i_in_mon,
    pbs_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_state_changes,
    output int   o_checked
);
    import pbs_pkg::*;

    typedef struct packed {
        logic buzz;
        logic busy;
    } t_beep_word;

    // Model state of the running pattern, idle from the start.
    t_rank  cur_rank  = RANK_NONE;
    t_phase cur_phase = '0;
    t_time  cur_left  = '0;

    t_beep_word beep_q[$];
    int         errors_seen   = 0;
    int         changes_seen  = 0;
    int         words_checked = 0;

    // Number of phases in each pattern.
    function automatic int unsigned phase_count(input t_rank rank);
        int unsigned n;
        case (rank)
            RANK_KEY:    n = 1;
            RANK_FINISH: n = 5;
            RANK_ERROR:  n = 7;
            default:     n = 0;
        endcase
        return n;
    endfunction

    // Length of one phase in milliseconds.
    function automatic t_time phase_ms(input t_rank rank, input t_phase ph);
        t_time ms;
        ms = '0;
        case (rank)
            RANK_KEY: begin
                ms = KEY_MS;
            end
            RANK_FINISH: begin
                case (ph)
                    3'd0, 3'd2: ms = 9'd200;
                    3'd1, 3'd3: ms = 9'd120;
                    3'd4:       ms = 9'd300;
                    default:    ms = '0;
                endcase
            end
            RANK_ERROR: begin
                if (ph < 3'd6) ms = 9'd100;
                else if (ph == 3'd6) ms = 9'd500;
            end
            default: begin
                ms = '0;
            end
        endcase
        return ms;
    endfunction

    // Apply one input word to the model and produce its result word.
    task automatic beeper_step(input logic op, input t_rank req, input t_ms ms,
                               output t_beep_word res, output logic moved);
        int unsigned rest;
        int unsigned steps;
        t_rank       old_rank;
        t_phase      old_phase;
        t_time       old_left;
        old_rank  = cur_rank;
        old_phase = cur_phase;
        old_left  = cur_left;
        rest      = ms;
        steps     = 0;
        if (op == OP_REQUEST) begin
            // A nonzero request at or above the running rank (re)starts.
            if (req != RANK_NONE && req >= cur_rank) begin
                cur_rank  = req;
                cur_phase = '0;
                cur_left  = phase_ms(req, '0);
            end
        end else begin
            // Consume whole phases while the elapsed time covers them.
            while (steps < 8 && cur_rank != RANK_NONE && rest >= cur_left) begin
                rest      = rest - cur_left;
                cur_phase = cur_phase + 3'd1;
                if (cur_phase >= phase_count(cur_rank)) begin
                    cur_rank = RANK_NONE;
                    cur_left = '0;
                end else begin
                    cur_left = phase_ms(cur_rank, cur_phase);
                end
                steps++;
            end
            if (cur_rank != RANK_NONE) begin
                cur_left = (rest < cur_left) ? t_time'(cur_left - rest) : '0;
            end
        end
        res.busy = (cur_rank != RANK_NONE);
        res.buzz = (cur_rank != RANK_NONE) && !cur_phase[0];
        moved = (cur_rank != old_rank) || (cur_phase != old_phase) ||
                (cur_left != old_left);
    endtask

    // Print one mismatch line and count it.
    task automatic report_error(input string msg);
        $display("[%0t] checker error: %s", $time, msg);
        errors_seen++;
    endtask

    // Predict on every accepted input word, compare every accepted result word.
    always @(posedge i_clk) begin
        t_beep_word want;
        t_beep_word got;
        logic       moved;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                beeper_step(i_in_mon.opcode, t_rank'(i_in_mon.requested_pattern),
                            i_in_mon.delta_ms, want, moved);
                beep_q.push_back(want);
                if (moved) changes_seen++;
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.buzz = i_out_mon.buzz;
                got.busy = i_out_mon.busy_res;
                if (beep_q.size() == 0) begin
                    report_error($sformatf("result word %b/%b with nothing expected",
                                           got.buzz, got.busy));
                end else begin
                    want = beep_q.pop_front();
                    if (got.buzz !== want.buzz) begin
                        report_error($sformatf("word %0d buzz got %b want %b",
                                               words_checked, got.buzz,
                                               want.buzz));
                    end
                    if (got.busy !== want.busy) begin
                        report_error($sformatf("word %0d busy_res got %b want %b",
                                               words_checked, got.busy, want.busy));
                    end
                end
                words_checked++;
            end
        end
        o_fail_count    <= errors_seen;
        o_pending       <= beep_q.size();
        o_state_changes <= changes_seen;
        o_checked       <= words_checked;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench of the beep pattern sequencer. A directed opening walks every
// pattern through its corner cases, then random request and update bursts
// run under random sender and receiver stalls, a back-to-back stretch, a long
// output hold and a full drain. A separate checker predicts and compares.
// ============================================================================
module tb_top;
    import pbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_WORDS   = 1520;

    logic clk = 1'b0;
    logic rst_n;

    int   fail_count;
    int   pending;
    int   state_changes;
    int   checked;
    int   words_sent;
    int   quiet_cycles;
    int   goal;
    bit   idle_on;
    int   hold_len;

    pbs_in_if  in_ch ();
    pbs_out_if out_ch ();

    priority_beep_pattern_sequencer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pbs_beep_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_state_changes (state_changes),
        .o_checked       (checked)
    );

    // Free-running clock.
    always #10 clk = ~clk;

    // Offer one word after an optional gap and wait until it is taken.
    task automatic send_word(input logic op, input logic [1:0] req, input t_ms ms);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.opcode            <= op;
        in_ch.requested_pattern <= req;
        in_ch.delta_ms          <= ms;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    // Elapsed time for an update, weighted toward phase-sized steps.
    function automatic t_ms pick_ms();
        t_ms ms;
        case ($urandom_range(0, 19))
            0: ms = '0;
            1: ms = t_ms'($urandom);
            2, 3, 4: begin
                case ($urandom_range(0, 4))
                    0:       ms = 16'd100;
                    1:       ms = 16'd120;
                    2:       ms = 16'd200;
                    3:       ms = 16'd300;
                    default: ms = 16'd500;
                endcase
            end
            5, 6:    ms = t_ms'($urandom_range(0, 1200));
            default: ms = t_ms'($urandom_range(1, 150));
        endcase
        return ms;
    endfunction

    // A pattern request followed by updates, with stray requests mixed in.
    task automatic send_burst();
        logic [1:0] rank;
        int         n_upd;
        int         k;
        rank  = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 3));
        n_upd = $urandom_range(1, 16);
        send_word(OP_REQUEST, rank, t_ms'($urandom));
        for (k = 0; k < n_upd; k++) begin
            if ($urandom_range(0, 6) == 0)
                send_word(OP_REQUEST, 2'($urandom), t_ms'($urandom));
            else
                send_word(OP_UPDATE, 2'($urandom), pick_ms());
        end
    endtask

    // Hold the sender until every predicted result word has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random stalls, or a long hold when one is requested.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 12) : 0;
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Main stimulus.
    initial begin
        words_sent = 0;
        idle_on    = 1'b1;
        hold_len   = 0;
        rst_n                   <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.opcode            <= OP_UPDATE;
        in_ch.requested_pattern <= RANK_NONE;
        in_ch.delta_ms          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Idle block: updates and a none request leave it idle.
        send_word(OP_UPDATE, RANK_NONE, 16'd0);
        send_word(OP_UPDATE, RANK_ERROR, 16'hFFFF);
        send_word(OP_REQUEST, RANK_NONE, 16'hFFFF);
        // Key beep: zero update, partial update, then exactly the rest.
        send_word(OP_REQUEST, RANK_KEY, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd299);
        send_word(OP_UPDATE, RANK_NONE, 16'd1);
        // Finish: lower rank ignored, equal rank restarts, exact phase end,
        // then an update far longer than the rest of the pattern.
        send_word(OP_REQUEST, RANK_FINISH, 16'd0);
        send_word(OP_REQUEST, RANK_KEY, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd150);
        send_word(OP_REQUEST, RANK_FINISH, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd200);
        send_word(OP_UPDATE, RANK_NONE, 16'hFFFF);
        // Error: ignored requests, a multi-phase step, restart, exact total.
        send_word(OP_REQUEST, RANK_ERROR, 16'd0);
        send_word(OP_REQUEST, RANK_FINISH, 16'd0);
        send_word(OP_REQUEST, RANK_NONE, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd100);
        send_word(OP_UPDATE, RANK_NONE, 16'd550);
        send_word(OP_REQUEST, RANK_ERROR, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd1100);
        // A higher rank preempts a running key beep.
        send_word(OP_REQUEST, RANK_KEY, 16'd0);
        send_word(OP_REQUEST, RANK_ERROR, 16'd0);
        send_word(OP_UPDATE, RANK_NONE, 16'd1099);
        send_word(OP_UPDATE, RANK_NONE, 16'd1);

        // Random bursts, idling switched on and off per burst.
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal - 950) begin
            idle_on = ($urandom_range(0, 4) != 0);
            send_burst();
        end

        // Sender pause until the block has returned every result.
        idle_on = 1'b1;
        wait_drained();

        // Back-to-back stretch with no idling on either side.
        idle_on = 1'b0;
        while (words_sent < goal - 650) send_burst();

        // Long receiver hold while the sender keeps offering words.
        hold_len = HOLD_CYCLES;
        repeat (3) send_burst();

        // Remaining bursts with mixed idling.
        while (words_sent < goal) begin
            idle_on = ($urandom_range(0, 4) != 0);
            send_burst();
        end

        idle_on = 1'b1;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Drove %0d input words (%0d changed the pattern state), checked %0d results,",
                 words_sent, state_changes, checked);
        $display("under random stalls, a back-to-back run, a long output hold and drains.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pbs_pkg.sv
rtl/core/pbs_if.sv
rtl/core/priority_beep_pattern_sequencer.sv
dv/pbs_beep_checker.sv
dv/tb_top.sv
